// File: rtl/pl0ts_pkg.sv
// Shared types, constants and keyword tables for the PL/0 token scanner.
package pl0ts_pkg;

  // Default widths of the offset and length fields, and queue depth
  localparam int OFFSET_BITS_DEF = 20;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int KW_COUNT = 11;
  localparam int KIND_BITS = 3;
  localparam int KWI_BITS = 4;
  localparam int CHAR_BITS = 8;

  // Scanner mode between bytes
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUM    = 2'd2,
    MODE_CLOSED = 2'd3
  } mode_t;

  // Token kind codes as they leave the block
  typedef enum logic [KIND_BITS-1:0] {
    KIND_IDENT   = 3'd0,
    KIND_NUM     = 3'd1,
    KIND_KEYWORD = 3'd2,
    KIND_OP      = 3'd3,
    KIND_EOF     = 3'd4,
    KIND_INVALID = 3'd5
  } kind_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Keyword text, last character in the lowest byte
  function automatic logic [71:0] kw_text(input logic [3:0] k);
    logic [71:0] s;
    unique case (k)
      4'd0:    s = 72'("begin");
      4'd1:    s = 72'("end");
      4'd2:    s = 72'("if");
      4'd3:    s = 72'("then");
      4'd4:    s = 72'("while");
      4'd5:    s = 72'("do");
      4'd6:    s = 72'("const");
      4'd7:    s = 72'("var");
      4'd8:    s = 72'("procedure");
      4'd9:    s = 72'("odd");
      4'd10:   s = 72'("call");
      default: s = '0;
    endcase
    return s;
  endfunction

  // Keyword length in characters
  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      4'd0:    l = 4'd5;
      4'd1:    l = 4'd3;
      4'd2:    l = 4'd2;
      4'd3:    l = 4'd4;
      4'd4:    l = 4'd5;
      4'd5:    l = 4'd2;
      4'd6:    l = 4'd5;
      4'd7:    l = 4'd3;
      4'd8:    l = 4'd9;
      4'd9:    l = 4'd3;
      4'd10:   l = 4'd4;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  // Character p of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [71:0] s;
    logic [3:0]  l;
    logic [3:0]  sh;
    s  = kw_text(k);
    l  = kw_len(k);
    sh = l - 4'd1 - p;
    if (p < l) begin
      return s[{sh, 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

endpackage

// File: rtl/pl0ts_front.sv
// Front end: byte classification, run tracking, keyword match and token build.
module pl0ts_front
  import pl0ts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int TOK_W = 1 + KIND_BITS + CHAR_BITS + KWI_BITS + LENGTH_BITS + OFFSET_BITS,
  localparam int ENT_W = 1 + 2 * TOK_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       char_code,
  input  logic             end_of_source,
  input  q_stat_t          q_stat,
  output logic             push,
  output logic [ENT_W-1:0] push_data
);

  mode_t                   mode, mode_next;
  logic [OFFSET_BITS-1:0]  pos, pos_next, pos_inc;
  logic [OFFSET_BITS-1:0]  run_start, run_start_next;
  logic [LENGTH_BITS-1:0]  run_length, run_length_next;
  logic [KW_COUNT-1:0]     match, match_next;

  logic fire;
  logic is_alpha, is_digit, is_space, is_punct, is_end, is_bad;
  logic extend, pending, has_cur, starting;
  logic kw_hit;
  logic [KWI_BITS-1:0] kwi;
  logic [TOK_W-1:0] pend_tok, cur_tok, tok0;
  kind_t pend_kind, cur_kind;

  assign in_ready = !q_stat.full;
  assign fire     = in_valid && in_ready;

  // Byte classes
  always_comb begin
    is_alpha = (char_code >= 8'h41 && char_code <= 8'h5A) ||
               (char_code >= 8'h61 && char_code <= 8'h7A);
    is_digit = char_code >= 8'h30 && char_code <= 8'h39;
    is_space = char_code == 8'h20 || (char_code >= 8'h09 && char_code <= 8'h0D);
    is_punct = char_code >= 8'h21 && char_code <= 8'h7E && !is_alpha && !is_digit;
    is_end   = end_of_source || char_code == 8'h00;
    is_bad   = !is_end && !is_space && !is_alpha && !is_digit && !is_punct;
  end

  // Run control
  always_comb begin
    extend   = !is_end && ((mode == MODE_IDENT && (is_alpha || is_digit)) ||
                           (mode == MODE_NUM && is_digit));
    pending  = (mode == MODE_IDENT || mode == MODE_NUM) && !extend;
    has_cur  = is_end || is_punct || is_bad;
    starting = mode != MODE_CLOSED && !extend && !is_end && (is_alpha || is_digit);
    pos_inc  = (pos == '1) ? pos : pos + OFFSET_BITS'(1);
  end

  // Keyword hit on the pending word
  always_comb begin
    kw_hit = 1'b0;
    kwi    = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (match[k] && run_length == LENGTH_BITS'(kw_len(4'(k)))) begin
        kw_hit = 1'b1;
        kwi    = kwi | KWI_BITS'(k);
      end
    end
  end

  // Next mode
  always_comb begin
    mode_next = mode;
    if (fire) begin
      unique case (mode)
        MODE_CLOSED: begin
          if (end_of_source) mode_next = MODE_IDLE;
        end
        default: begin
          if (extend)        mode_next = mode;
          else if (is_end)   mode_next = MODE_IDLE;
          else if (is_alpha) mode_next = MODE_IDENT;
          else if (is_digit) mode_next = MODE_NUM;
          else if (is_bad)   mode_next = MODE_CLOSED;
          else               mode_next = MODE_IDLE;
        end
      endcase
    end
  end

  // Token words and queue write
  always_comb begin
    pend_kind = (mode == MODE_IDENT) ? (kw_hit ? KIND_KEYWORD : KIND_IDENT) : KIND_NUM;
    pend_tok  = {1'b0, pend_kind, 8'h00, (kw_hit && mode == MODE_IDENT) ? kwi : 4'd0,
                 run_length, run_start};
    if (is_end)      cur_kind = KIND_EOF;
    else if (is_bad) cur_kind = KIND_INVALID;
    else             cur_kind = KIND_OP;
    cur_tok   = {is_end || is_bad, cur_kind, is_end ? 8'h00 : char_code, 4'd0,
                 is_end ? LENGTH_BITS'(0) : LENGTH_BITS'(1), pos};
    tok0      = pending ? pend_tok : cur_tok;
    push      = fire && mode != MODE_CLOSED && !extend && (pending || has_cur);
    push_data = {pending && has_cur, cur_tok, tok0};
  end

  // Position, run and match updates
  always_comb begin
    pos_next        = pos;
    run_start_next  = run_start;
    run_length_next = run_length;
    match_next      = match;
    if (fire) begin
      if (mode == MODE_CLOSED) begin
        if (end_of_source) pos_next = '0;
      end else if (is_end) begin
        pos_next = '0;
      end else begin
        pos_next = pos_inc;
      end
      if (mode != MODE_CLOSED && extend) begin
        run_length_next = (run_length == '1) ? run_length : run_length + LENGTH_BITS'(1);
        for (int k = 0; k < KW_COUNT; k++) begin
          match_next[k] = match[k] && run_length < LENGTH_BITS'(kw_len(4'(k))) &&
                          char_code == kw_char(4'(k), run_length[3:0]);
        end
      end else if (starting) begin
        run_start_next  = pos;
        run_length_next = LENGTH_BITS'(1);
        for (int k = 0; k < KW_COUNT; k++) begin
          match_next[k] = char_code == kw_char(4'(k), 4'd0);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      pos        <= '0;
      run_start  <= '0;
      run_length <= '0;
      match      <= '0;
    end else begin
      mode       <= mode_next;
      pos        <= pos_next;
      run_start  <= run_start_next;
      run_length <= run_length_next;
      match      <= match_next;
    end
  end

  // Checks
  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == MODE_CLOSED) |-> !push)
    else $error("word queued while source closed");
  a_eof_rewinds: assert property (@(posedge clk) disable iff (rst)
    (fire && mode != MODE_CLOSED && is_end) |=> (pos == '0 && mode == MODE_IDLE))
    else $error("position not rewound after end of file");
  a_bad_closes: assert property (@(posedge clk) disable iff (rst)
    (fire && mode != MODE_CLOSED && is_bad) |=> mode == MODE_CLOSED)
    else $error("invalid byte did not close source");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("write into full queue");

endmodule

// File: rtl/pl0ts_queue.sv
// Short queue of token pairs between the front end and the output stage.
module pl0ts_queue
  import pl0ts_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output q_stat_t          stat
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = count == CNT_W'(DEPTH);
  assign stat.empty = count == '0;
  assign head       = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  // Checks
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("read from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("fill count out of step");

endmodule

// File: rtl/pl0ts_back.sv
// Output stage: splits queued token pairs and holds the outgoing word.
module pl0ts_back
  import pl0ts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int TOK_W  = 1 + KIND_BITS + CHAR_BITS + KWI_BITS + LENGTH_BITS + OFFSET_BITS,
  localparam int ENT_W  = 1 + 2 * TOK_W,
  localparam int RAW_W  = OFFSET_BITS + LENGTH_BITS + KWI_BITS + CHAR_BITS,
  localparam int DATA_W = ((RAW_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ENT_W-1:0]     head,
  input  q_stat_t              q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_data,
  output logic [KIND_BITS-1:0] out_kind,
  output logic                 out_last
);

  logic             sel;
  logic             load;
  logic             two;
  logic [TOK_W-1:0] tok_cur, tok_out;

  // Pick the next token of the head entry
  always_comb begin
    two     = head[ENT_W-1];
    tok_cur = sel ? head[2*TOK_W-1 -: TOK_W] : head[TOK_W-1:0];
    load    = !q_stat.empty && (!out_valid || out_ready);
    pop     = load && (sel || !two);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= !sel && two;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) tok_out <= tok_cur;
  end

  // Unpack: final, kind, char, keyword index, length, offset
  assign out_data = DATA_W'(tok_out[RAW_W-1:0]);
  assign out_kind = tok_out[TOK_W-2 -: KIND_BITS];
  assign out_last = tok_out[TOK_W-1];

  // Checks
  a_second_half: assert property (@(posedge clk) disable iff (rst)
    sel |-> !q_stat.empty)
    else $error("second token pending with empty queue");

endmodule

// File: rtl/pl0_token_scanner.sv
// Top level of the PL/0 token scanner: front end, token queue and output stage.
//
// Takes one source byte per word on s_axis and returns token descriptors on m_axis.
// A byte is taken every cycle while the token queue (QUEUE_DEPTH entries, each holding
// the one or two tokens that a byte causes) has room; a token passes through the token
// queue and then the output register, which delivers one token per cycle while
// m_axis_tready is high, so a byte that closes a run and also yields its own token gives
// two words one after the other. Keyword matching is done a character at a time as the
// word arrives, so classification and lookup are done combinationally in the front end.
// After an invalid byte all bytes are dropped until a word with the end flag set; after
// an end of file the byte offset starts again at zero. Offsets and lengths saturate.
module pl0_token_scanner
  import pl0ts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int RAW_W  = OFFSET_BITS + LENGTH_BITS + KWI_BITS + CHAR_BITS,
  localparam int DATA_W = ((RAW_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // char_code
  input  logic                 s_axis_tuser,  // end_of_source
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // start_offset, token_length, keyword_index, single_char, zero fill
  output logic [DATA_W-1:0]    m_axis_tdata,
  output logic [KIND_BITS-1:0] m_axis_tuser,  // token_kind
  output logic                 m_axis_tlast   // final_token
);

  localparam int TOK_W = 1 + KIND_BITS + CHAR_BITS + KWI_BITS + LENGTH_BITS + OFFSET_BITS;
  localparam int ENT_W = 1 + 2 * TOK_W;

  q_stat_t          q_stat;
  logic             push, pop;
  logic [ENT_W-1:0] push_data, head;

  pl0ts_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .char_code     (s_axis_tdata),
    .end_of_source (s_axis_tuser),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  pl0ts_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  pl0ts_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule
